### src/sgbr_pkg.sv
package sgbr_pkg;

  localparam int CFG_W      = 16;
  localparam int CH_W       = 8;
  localparam int CNT_W      = 8;
  localparam int MS_W       = 16;
  localparam int IN_TIME_W  = 32;
  localparam int TIER_COUNT = 17;
  localparam int MULT_W     = 9;

  localparam logic [CH_W-1:0]  LOCK_RESET = 8'd0;
  localparam logic [CNT_W-1:0] THR_RESET  = 8'd10;
  localparam logic [MS_W-1:0]  BASE_RESET = 16'd2000;
  localparam logic [MS_W-1:0]  MAX_RESET  = 16'd30000;
  localparam logic [CNT_W-1:0] CNT_MAX    = 8'd255;

  localparam logic       MODE_SEND    = 1'b0;
  localparam logic       MODE_NOTICE  = 1'b1;
  localparam logic [1:0] SEND_OK      = 2'd0;
  localparam logic [1:0] SEND_ARG_ERR = 2'd1;

  typedef enum logic [1:0] {
    CFG_LOCK,
    CFG_THR,
    CFG_BASE,
    CFG_MAX
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RES_OK,
    RES_BAD_ARGS,
    RES_PAUSED,
    RES_MISMATCH,
    RES_RECOVERING,
    RES_ARG_ERR,
    RES_OTHER_ERR
  } res_code_t;

  // Entry k holds the failure count at which tier k+1 begins, saturated at 256.
  typedef logic [TIER_COUNT-1:0][MULT_W-1:0] thr_mult_t;

  typedef struct packed {
    logic [CH_W-1:0] lock_channel;
    logic [MS_W-1:0] base_ms;
    logic [MS_W-1:0] max_ms;
    thr_mult_t       thr_mult;
  } cfg_t;

  typedef struct packed {
    logic                 mode;
    logic [IN_TIME_W-1:0] now_ms;
    logic                 args_valid;
    logic                 channel_read_ok;
    logic [CH_W-1:0]      home_ch;
    logic [CH_W-1:0]      peer_ch;
    logic                 link_connected;
    logic [1:0]           send_status;
  } item_t;

  typedef struct packed {
    res_code_t        code;
    logic             posted;
    logic [CNT_W-1:0] fails;
    logic [MS_W-1:0]  backoff;
  } res_t;

  function automatic logic [MULT_W-1:0] thr_multiple(input logic [CNT_W-1:0] thr,
                                                     input int unsigned k);
    logic [CNT_W-1:0] t;
    logic [12:0]      p;
    t = (thr == '0) ? CNT_W'(1) : thr;
    p = 13'(t) * 13'(k);
    return (p > 13'd256) ? MULT_W'(256) : p[MULT_W-1:0];
  endfunction

endpackage

### src/send_guard_backoff_recovery.sv
// Path: a result passes through the input register, then the result register, before
// it is offered and can make its own transfer.
// Throughput: one item per cycle while results are taken; the guard state updates
// in the same cycle an item leaves the input register, so the next item sees it at once.
// Reset (rst, synchronous, active high) empties both registers, clears the guard
// state and loads the configuration defaults; no clearing pass is needed.
module send_guard_backoff_recovery #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Item channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [31:0] now_ms,
  input  logic        args_valid,
  input  logic        channel_read_ok,
  input  logic [7:0]  home_ch,
  input  logic [7:0]  peer_ch,
  input  logic        link_connected,
  input  logic [1:0]  send_status,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_code,
  output logic        connection_lost_posted,
  output logic [7:0]  failure_count,
  output logic [15:0] backoff_ms,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import sgbr_pkg::*;

  cfg_t  cfg;
  item_t s1_item;
  logic  s1_valid;
  res_t  res;
  res_t  res_q;
  logic  advance;
  logic  take;

  // Both registers move together: the result register frees up whenever its
  // transfer completes, and the input register may refill in that same cycle.
  // So a new item is taken even while a finished result is still waiting,
  // as long as the input register is empty.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign take     = s1_valid && advance;

  sgbr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The core holds the recovery flags, failure counter and pause end time,
  // and decides the result of the item in the input register.
  sgbr_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.mode            <= mode;
      s1_item.now_ms          <= now_ms;
      s1_item.args_valid      <= args_valid;
      s1_item.channel_read_ok <= channel_read_ok;
      s1_item.home_ch         <= home_ch;
      s1_item.peer_ch         <= peer_ch;
      s1_item.link_connected  <= link_connected;
      s1_item.send_status     <= send_status;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign result_code            = res_q.code;
  assign connection_lost_posted = res_q.posted;
  assign failure_count          = res_q.fails;
  assign backoff_ms             = res_q.backoff;

  // A connection-lost post only comes from a mismatch or a radio argument error.
  a_post_code : assert property (@(posedge clk) disable iff (rst)
    out_valid && connection_lost_posted |->
      res_q.code == RES_MISMATCH || res_q.code == RES_ARG_ERR)
    else $error("connection lost posted with an unexpected result code");

  // A pause is only started by a failed radio send.
  a_pause_code : assert property (@(posedge clk) disable iff (rst)
    out_valid && backoff_ms != '0 |->
      res_q.code == RES_ARG_ERR || res_q.code == RES_OTHER_ERR)
    else $error("pause started by an item that did not fail at the radio");

  // A started pause never exceeds the configured cap.
  a_pause_cap : assert property (@(posedge clk) disable iff (rst)
    out_valid && backoff_ms != '0 |-> backoff_ms <= cfg.max_ms)
    else $error("pause length above the cap");

  // With both registers full and the result stalled, no new transfer is taken.
  a_stall : assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready && !take)
    else $error("item accepted while the pipeline is stalled and full");

endmodule

### src/sgbr_cfg.sv
module sgbr_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [15:0]           cfg_wdata,
  output sgbr_pkg::cfg_t        cfg
);
  import sgbr_pkg::*;

  // The tier boundaries are products of the threshold with small constants,
  // formed when the threshold is written so the item path only compares.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lock_channel <= LOCK_RESET;
      cfg.base_ms      <= BASE_RESET;
      cfg.max_ms       <= MAX_RESET;
      for (int k = 0; k < TIER_COUNT; k++) begin
        cfg.thr_mult[k] <= thr_multiple(THR_RESET, k + 1);
      end
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_LOCK: cfg.lock_channel <= cfg_wdata[CH_W-1:0];
        CFG_THR: begin
          for (int k = 0; k < TIER_COUNT; k++) begin
            cfg.thr_mult[k] <= thr_multiple(cfg_wdata[CNT_W-1:0], k + 1);
          end
        end
        CFG_BASE: cfg.base_ms <= cfg_wdata[MS_W-1:0];
        CFG_MAX:  cfg.max_ms  <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### src/sgbr_backoff.sv
module sgbr_backoff (
  input  logic [7:0]     fails,
  input  sgbr_pkg::cfg_t cfg,
  output logic           started,
  output logic [15:0]    pause
);
  import sgbr_pkg::*;

  logic [TIER_COUNT-1:0] ge;
  logic [3:0]            shift;
  logic [30:0]           shifted;

  always_comb begin
    for (int k = 0; k < TIER_COUNT; k++) begin
      ge[k] = ({1'b0, fails} >= cfg.thr_mult[k]);
    end
    // Tier boundaries rise with k, so the highest one passed gives the shift.
    shift = '0;
    for (int k = 1; k < TIER_COUNT - 1; k++) begin
      if (ge[k]) begin
        shift = 4'(k);
      end
    end
    shifted = {15'd0, cfg.base_ms} << shift;
    started = ge[0];
    if (cfg.base_ms == '0) begin
      pause = '0;
    end else if (ge[TIER_COUNT-1]) begin
      pause = cfg.max_ms;
    end else if (shifted > {15'd0, cfg.max_ms}) begin
      pause = cfg.max_ms;
    end else begin
      pause = shifted[MS_W-1:0];
    end
  end

endmodule

### src/sgbr_core.sv
module sgbr_core #(
  parameter int TIME_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  sgbr_pkg::item_t item,
  input  sgbr_pkg::cfg_t  cfg,
  output sgbr_pkg::res_t  res
);
  import sgbr_pkg::*;

  logic                 recovery_active, recovery_active_next;
  logic                 recovery_latched, recovery_latched_next;
  logic [CNT_W-1:0]     fails, fails_next;
  logic [TIME_BITS-1:0] paused_until, paused_until_next;

  logic [TIME_BITS-1:0] now_ext;
  logic [CNT_W-1:0]     fails_clr, fails_rec, fails_inc;
  logic                 coherent, rec_clear, rec_hold;
  logic                 started;
  logic [MS_W-1:0]      pause;

  assign now_ext   = TIME_BITS'(item.now_ms);
  assign fails_clr = (paused_until != '0) ? '0 : fails;
  assign rec_clear = recovery_active && item.link_connected;
  assign rec_hold  = recovery_active && !item.link_connected;
  assign fails_rec = rec_clear ? '0 : fails_clr;
  assign fails_inc = (fails_rec == CNT_MAX) ? CNT_MAX : fails_rec + CNT_W'(1);
  assign coherent  = !item.channel_read_ok ||
                     (((item.peer_ch == '0) ||
                       (item.peer_ch == item.home_ch)) &&
                      ((cfg.lock_channel == '0) ||
                       (item.home_ch == cfg.lock_channel)));

  sgbr_backoff u_backoff (
    .fails   (fails_inc),
    .cfg     (cfg),
    .started (started),
    .pause   (pause)
  );

  always_comb begin
    recovery_active_next  = recovery_active;
    recovery_latched_next = recovery_latched;
    fails_next            = fails;
    paused_until_next     = paused_until;
    res.code              = RES_OK;
    res.posted            = 1'b0;
    res.backoff           = '0;
    if (item.mode == MODE_NOTICE) begin
      if (item.link_connected) begin
        recovery_active_next  = 1'b0;
        recovery_latched_next = 1'b0;
        fails_next            = '0;
        paused_until_next     = '0;
      end else begin
        recovery_active_next = 1'b1;
      end
    end else if (!item.args_valid) begin
      res.code = RES_BAD_ARGS;
    end else if (paused_until > now_ext) begin
      res.code = RES_PAUSED;
    end else begin
      paused_until_next = '0;
      fails_next        = fails_clr;
      if (!coherent) begin
        res.code = RES_MISMATCH;
        if (!recovery_latched) begin
          recovery_active_next  = 1'b1;
          recovery_latched_next = 1'b1;
          res.posted            = 1'b1;
        end
      end else begin
        recovery_active_next  = rec_hold;
        recovery_latched_next = rec_clear ? 1'b0 : recovery_latched;
        fails_next            = fails_rec;
        if (rec_hold) begin
          res.code = RES_RECOVERING;
        end else if (item.send_status == SEND_OK) begin
          fails_next = '0;
          res.code   = RES_OK;
        end else begin
          fails_next = fails_inc;
          if (item.send_status == SEND_ARG_ERR) begin
            res.code = RES_ARG_ERR;
            if (!recovery_latched_next) begin
              recovery_active_next  = 1'b1;
              recovery_latched_next = 1'b1;
              res.posted            = 1'b1;
            end
          end else begin
            res.code = RES_OTHER_ERR;
          end
          if (started) begin
            res.backoff       = pause;
            paused_until_next = now_ext + TIME_BITS'(pause);
          end
        end
      end
    end
    res.fails = fails_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recovery_active  <= 1'b0;
      recovery_latched <= 1'b0;
      fails            <= '0;
      paused_until     <= '0;
    end else if (take) begin
      recovery_active  <= recovery_active_next;
      recovery_latched <= recovery_latched_next;
      fails            <= fails_next;
      paused_until     <= paused_until_next;
    end
  end

endmodule

### tb/send_guard_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port of the send guard, keeps its own
// copy of the guard state, and scores every result against the verdict it predicts.
module send_guard_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        mode,
  input  logic [31:0] now_ms,
  input  logic        args_valid,
  input  logic        channel_read_ok,
  input  logic [7:0]  home_ch,
  input  logic [7:0]  peer_ch,
  input  logic        link_connected,
  input  logic [1:0]  send_status,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  result_code,
  input  logic        connection_lost_posted,
  input  logic [7:0]  failure_count,
  input  logic [15:0] backoff_ms,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          mismatch_count,
  output int          verdicts_pending
);
  import sgbr_pkg::*;

  logic [CH_W-1:0]      lock_q;
  logic [CNT_W-1:0]     thr_q;
  logic [MS_W-1:0]      base_q;
  logic [MS_W-1:0]      max_q;
  logic                 rec_active;
  logic                 rec_latched;
  logic [CNT_W-1:0]     fails;
  logic [IN_TIME_W-1:0] pause_end;

  res_t expected_verdicts[$];
  int   errors = 0;

  function automatic void clear_guard();
    rec_active  = 1'b0;
    rec_latched = 1'b0;
    fails       = '0;
    pause_end   = '0;
  endfunction

  // Recovery is latched once; only the latching attempt posts the event.
  function automatic logic latch_recovery();
    if (rec_latched) return 1'b0;
    rec_active  = 1'b1;
    rec_latched = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [MS_W-1:0] backoff_for(input logic [IN_TIME_W-1:0] now);
    logic [CNT_W-1:0]     thr;
    int unsigned          tier;
    int unsigned          shift;
    logic [IN_TIME_W-1:0] pause;
    thr = (thr_q == '0) ? CNT_W'(1) : thr_q;
    if (fails < thr) return '0;
    tier  = fails / thr;
    shift = (tier > 1) ? tier - 1 : 0;
    if (base_q == '0) begin
      pause = '0;
    end else if (shift >= 16) begin
      pause = IN_TIME_W'(max_q);
    end else begin
      pause = IN_TIME_W'(base_q) << shift;
      if (pause > IN_TIME_W'(max_q)) pause = IN_TIME_W'(max_q);
    end
    pause_end = now + pause;
    return pause[MS_W-1:0];
  endfunction

  function automatic res_t judge_attempt(input item_t it);
    res_t r;
    logic coherent;
    r.code    = RES_OK;
    r.posted  = 1'b0;
    r.backoff = '0;
    if (it.mode == MODE_NOTICE) begin
      if (it.link_connected) clear_guard();
      else rec_active = 1'b1;
    end else if (!it.args_valid) begin
      r.code = RES_BAD_ARGS;
    end else if (pause_end > it.now_ms) begin
      r.code = RES_PAUSED;
    end else begin
      // An expired pause also restarts the failure count.
      if (pause_end != '0) begin
        pause_end = '0;
        fails     = '0;
      end
      coherent = 1'b1;
      if (it.channel_read_ok) begin
        coherent = (it.peer_ch == '0 || it.peer_ch == it.home_ch) &&
                   (lock_q == '0 || it.home_ch == lock_q);
      end
      if (!coherent) begin
        r.posted = latch_recovery();
        r.code   = RES_MISMATCH;
      end else begin
        if (rec_active && it.link_connected) clear_guard();
        if (rec_active) begin
          r.code = RES_RECOVERING;
        end else if (it.send_status == SEND_OK) begin
          fails  = '0;
          r.code = RES_OK;
        end else begin
          if (fails != CNT_MAX) fails++;
          if (it.send_status == SEND_ARG_ERR) begin
            r.posted = latch_recovery();
            r.code   = RES_ARG_ERR;
          end else begin
            r.code = RES_OTHER_ERR;
          end
          r.backoff = backoff_for(it.now_ms);
        end
      end
    end
    r.fails = fails;
    return r;
  endfunction

  always @(posedge clk) begin
    item_t seen;
    res_t  got;
    res_t  want;
    if (rst) begin
      lock_q = LOCK_RESET;
      thr_q  = THR_RESET;
      base_q = BASE_RESET;
      max_q  = MAX_RESET;
      clear_guard();
      expected_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_LOCK: lock_q = cfg_wdata[CH_W-1:0];
          CFG_THR:  thr_q  = cfg_wdata[CNT_W-1:0];
          CFG_BASE: base_q = cfg_wdata;
          CFG_MAX:  max_q  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        seen.mode            = mode;
        seen.now_ms          = now_ms;
        seen.args_valid      = args_valid;
        seen.channel_read_ok = channel_read_ok;
        seen.home_ch         = home_ch;
        seen.peer_ch         = peer_ch;
        seen.link_connected  = link_connected;
        seen.send_status     = send_status;
        expected_verdicts.push_back(judge_attempt(seen));
      end
      if (out_valid && out_ready) begin
        got.code    = res_code_t'(result_code);
        got.posted  = connection_lost_posted;
        got.fails   = failure_count;
        got.backoff = backoff_ms;
        if (expected_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: code %0d posted %0d fails %0d backoff %0d",
                     got.code, got.posted, got.fails, got.backoff);
          end
        end else begin
          want = expected_verdicts.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t: expected code %0d posted %0d fails %0d backoff %0d",
                       $realtime, want.code, want.posted, want.fails, want.backoff);
              $display("                 got code %0d posted %0d fails %0d backoff %0d",
                       got.code, got.posted, got.fails, got.backoff);
            end
          end
        end
      end
    end
    mismatch_count   <= errors;
    verdicts_pending <= expected_verdicts.size();
  end

endmodule

### tb/send_guard_backoff_recovery_tb.sv
`timescale 1ns / 100ps

// Top of the send guard bench. This module only makes stimulus and gives the
// verdict; all prediction and scoring lives in the checker beside the block.
module send_guard_backoff_recovery_tb;
  import sgbr_pkg::*;

  // Cycles without any transfer on either channel before the run is declared hung.
  // The worst correct gap is a long random stall run, far below this.
  localparam int QUIET_LIMIT = 4000;

  // Radio outcomes that the package does not name.
  localparam logic [1:0] SEND_OTHER    = 2'd2;
  localparam logic [1:0] SEND_RESERVED = 2'd3;

  logic        clk             = 1'b0;
  logic        rst             = 1'b1;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic        mode            = MODE_SEND;
  logic [31:0] now_ms          = '0;
  logic        args_valid      = 1'b0;
  logic        channel_read_ok = 1'b0;
  logic [7:0]  home_ch         = '0;
  logic [7:0]  peer_ch         = '0;
  logic        link_connected  = 1'b0;
  logic [1:0]  send_status     = SEND_OK;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [2:0]  result_code;
  logic        connection_lost_posted;
  logic [7:0]  failure_count;
  logic [15:0] backoff_ms;
  logic        cfg_we          = 1'b0;
  logic [1:0]  cfg_addr        = '0;
  logic [15:0] cfg_wdata       = '0;

  int mismatch_count;
  int verdicts_pending;
  int quiet_cycles = 0;

  // Stimulus knobs. The register copies here only steer the random items toward
  // interesting times and channels; they take no part in any prediction.
  int          idle_pct  = 0;
  int          stall_pct = 0;
  logic [7:0]  set_lock  = LOCK_RESET;
  logic [15:0] set_base  = BASE_RESET;
  logic [15:0] set_max   = MAX_RESET;
  logic [31:0] now_track = '0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  send_guard_backoff_recovery u_dut (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .mode                   (mode),
    .now_ms                 (now_ms),
    .args_valid             (args_valid),
    .channel_read_ok        (channel_read_ok),
    .home_ch                (home_ch),
    .peer_ch                (peer_ch),
    .link_connected         (link_connected),
    .send_status            (send_status),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .result_code            (result_code),
    .connection_lost_posted (connection_lost_posted),
    .failure_count          (failure_count),
    .backoff_ms             (backoff_ms),
    .cfg_we                 (cfg_we),
    .cfg_addr               (cfg_addr),
    .cfg_wdata              (cfg_wdata)
  );

  send_guard_checker u_check (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .mode                   (mode),
    .now_ms                 (now_ms),
    .args_valid             (args_valid),
    .channel_read_ok        (channel_read_ok),
    .home_ch                (home_ch),
    .peer_ch                (peer_ch),
    .link_connected         (link_connected),
    .send_status            (send_status),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .result_code            (result_code),
    .connection_lost_posted (connection_lost_posted),
    .failure_count          (failure_count),
    .backoff_ms             (backoff_ms),
    .cfg_we                 (cfg_we),
    .cfg_addr               (cfg_addr),
    .cfg_wdata              (cfg_wdata),
    .mismatch_count         (mismatch_count),
    .verdicts_pending       (verdicts_pending)
  );

  // The receiver stalls each cycle with the probability of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hang detection: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item, first letting the sender idle at random, and returns at the
  // edge where the transfer happens. Valid is only lowered when a gap follows, so
  // back-to-back items keep it high without a glitch.
  task automatic push_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    mode            <= it.mode;
    now_ms          <= it.now_ms;
    args_valid      <= it.args_valid;
    channel_read_ok <= it.channel_read_ok;
    home_ch         <= it.home_ch;
    peer_ch         <= it.peer_ch;
    link_connected  <= it.link_connected;
    send_status     <= it.send_status;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_one(input logic m, input logic [31:0] now, input logic args,
                          input logic rok, input logic [7:0] home, input logic [7:0] peer,
                          input logic conn, input logic [1:0] status);
    item_t it;
    it.mode            = m;
    it.now_ms          = now;
    it.args_valid      = args;
    it.channel_read_ok = rok;
    it.home_ch         = home;
    it.peer_ch         = peer;
    it.link_connected  = conn;
    it.send_status     = status;
    push_item(it);
  endtask

  // Stops offering items, waits until every predicted result has been delivered
  // and lets the two-stage pipeline settle. The pending count is registered, so
  // the first edge only lets it catch up.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write per cycle; write enable stays high across the sequence.
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] lock, input logic [7:0] thr,
                               input logic [15:0] base, input logic [15:0] mx);
    write_reg(CFG_LOCK, 16'(lock));
    write_reg(CFG_THR, 16'(thr));
    write_reg(CFG_BASE, base);
    write_reg(CFG_MAX, mx);
    cfg_we   <= 1'b0;
    set_lock = lock;
    set_base = base;
    set_max  = mx;
  endtask

  // Builds one random item. Most send times follow a running clock that moves in
  // steps around the pause length, so pauses both hold and expire. A share of
  // times is pinned to the value at which a capped pause ends exactly at the wrap
  // (or to zero when the base is zero), which keeps the pause empty and lets the
  // failure count climb through many tiers up to saturation.
  function automatic item_t random_item(input int ok_pct, input int pin_pct,
                                        input int notice_pct);
    item_t it;
    int    sel;
    sel = $urandom_range(99);
    if (sel < pin_pct) begin
      now_track = (set_base == '0) ? 32'd0 : 32'd0 - 32'(set_max);
    end else if (sel < pin_pct + 8) begin
      now_track = $urandom;
    end else if (sel < pin_pct + 11) begin
      now_track = '1;
    end else if (sel < pin_pct + 14) begin
      now_track = '0;
    end else begin
      now_track = now_track + $urandom_range(32'(set_max) + 32'(set_max) / 2);
    end
    it.now_ms          = now_track;
    it.mode            = ($urandom_range(99) < notice_pct) ? MODE_NOTICE : MODE_SEND;
    it.args_valid      = ($urandom_range(99) >= 5);
    it.channel_read_ok = ($urandom_range(99) >= 10);
    if (set_lock != '0 && $urandom_range(99) < 85) it.home_ch = set_lock;
    else it.home_ch = 8'($urandom);
    sel = $urandom_range(99);
    if (sel < 45) it.peer_ch = it.home_ch;
    else if (sel < 80) it.peer_ch = '0;
    else it.peer_ch = 8'($urandom);
    it.link_connected = ($urandom_range(99) < 75);
    if ($urandom_range(99) < ok_pct) begin
      it.send_status = SEND_OK;
    end else begin
      sel = $urandom_range(99);
      if (sel < 15) it.send_status = SEND_ARG_ERR;
      else if (sel < 25) it.send_status = SEND_RESERVED;
      else it.send_status = SEND_OTHER;
    end
    return it;
  endfunction

  task automatic run_random(input int n, input int idle, input int stall, input int ok_pct,
                            input int pin_pct, input int notice_pct);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) push_item(random_item(ok_pct, pin_pct, notice_pct));
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: lock off, ten failures per tier,
    // 2000 ms base, 30000 ms cap. Sender and receiver never idle here.
    idle_pct  = 0;
    stall_pct = 0;
    // A disconnect notice holds recovery; a send while still disconnected is
    // refused, and a send that sees the link back clears it and goes through.
    send_one(MODE_NOTICE, 32'd100, 1'b1, 1'b1, 8'd1, 8'd1, 1'b0, SEND_OK);
    send_one(MODE_SEND, '1, 1'b0, 1'b1, 8'd1, 8'd1, 1'b1, SEND_OK);
    send_one(MODE_SEND, 32'd200, 1'b1, 1'b1, 8'd1, 8'd1, 1'b0, SEND_OK);
    send_one(MODE_SEND, 32'd300, 1'b1, 1'b1, 8'd1, 8'd1, 1'b1, SEND_OK);
    // Channel mismatch posts the connection-lost event only the first time.
    send_one(MODE_SEND, 32'd400, 1'b1, 1'b1, 8'd255, 8'd1, 1'b1, SEND_OK);
    send_one(MODE_SEND, 32'd410, 1'b1, 1'b1, 8'd255, 8'd1, 1'b1, SEND_OK);
    send_one(MODE_NOTICE, 32'd420, 1'b1, 1'b1, 8'd1, 8'd1, 1'b1, SEND_OK);
    // An unreadable home channel counts as coherent; the reserved status is an
    // ordinary failure, and an argument error latches recovery.
    send_one(MODE_SEND, 32'd500, 1'b1, 1'b0, 8'd3, 8'd9, 1'b1, SEND_RESERVED);
    send_one(MODE_SEND, 32'd510, 1'b1, 1'b1, 8'd11, 8'd0, 1'b1, SEND_ARG_ERR);
    // A connected send clears recovery and the count before failing again.
    send_one(MODE_SEND, 32'd520, 1'b1, 1'b1, 8'd11, 8'd11, 1'b1, SEND_OTHER);
    for (int i = 0; i < 8; i++) begin
      send_one(MODE_SEND, 32'd1000 + 32'(i), 1'b1, 1'b1, 8'd11, 8'd11, 1'b1, SEND_OTHER);
    end
    // The tenth failure starts a pause that ends exactly at the time wrap, so it
    // leaves no pause behind; the next failure starts a real one.
    send_one(MODE_SEND, 32'hFFFF_F830, 1'b1, 1'b1, 8'd11, 8'd11, 1'b1, SEND_OTHER);
    send_one(MODE_SEND, 32'd1000, 1'b1, 1'b1, 8'd11, 8'd11, 1'b1, SEND_OTHER);
    // One millisecond before the end the send is paused; at the end it runs.
    send_one(MODE_SEND, 32'd2999, 1'b1, 1'b1, 8'd11, 8'd11, 1'b1, SEND_OK);
    send_one(MODE_SEND, 32'd3000, 1'b1, 1'b1, 8'd11, 8'd11, 1'b1, SEND_OK);
    drain();

    // Random phases. Each one after the first rewrites every register while the block
    // is empty, and each sets a mix of sender idling and receiver stalls.
    run_random(130, 80, 0, 35, 10, 8);

    load_settings(8'd0, 8'd1, 16'd1, 16'd65535);
    run_random(130, 0, 80, 30, 10, 8);

    load_settings(8'd255, 8'd255, 16'd65535, 16'd1);
    run_random(150, 10, 10, 3, 40, 2);

    // Zero threshold acts as one, and a zero base gives empty pauses.
    load_settings(8'd0, 8'd0, 16'd0, 16'd65535);
    run_random(120, 0, 0, 20, 60, 5);

    // Unbroken failure runs on a one-millisecond cap: the count saturates and
    // the tier grows past the width of the pause.
    load_settings(8'd6, 8'd1, 16'd1, 16'd1);
    run_random(250, 80, 0, 0, 100, 0);

    for (int p = 0; p < 2; p++) begin
      load_settings(($urandom_range(1) != 0) ? 8'($urandom) : 8'd0,
                    8'($urandom_range(4, 1)), 16'($urandom_range(5000, 1)),
                    16'($urandom_range(65535, 1)));
      if (p == 0) run_random(150, 0, 80, 30, 10, 8);
      else run_random(150, 10, 10, 30, 10, 8);
    end

    // A final settle with the receiver always ready, so a stray extra result
    // would still be caught by the checker.
    stall_pct = 0;
    drain();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
